[rtl/core/ecu_pkg.sv]
// Shared types, constants and helpers for the easing curve unit.
package ecu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SEL_W     = 4;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int SIN_G     = 28;
  localparam int PH_W      = FRAC_BITS + 2;

  localparam logic [30:0] TWO_PI_G = 31'd1686629713;

  // curve selectors
  typedef enum logic [SEL_W-1:0] {
    FN_LINEAR     = 4'd0,
    FN_ACCDEC     = 4'd1,
    FN_ACCEL      = 4'd2,
    FN_ANTIC      = 4'd3,
    FN_ANTICOVER  = 4'd4,
    FN_BOUNCE     = 4'd5,
    FN_CYCLE      = 4'd6,
    FN_DECEL      = 4'd7,
    FN_OVERSHOOT  = 4'd8
  } func_e;

  // Q.16 constants
  localparam int Q_ONE      = 65536;
  localparam int Q_K52      = 163840;   // 2.5
  localparam int Q_K32      = 98304;    // 1.5
  localparam int Q_BX_SCALE = 73571;    // 1.1226
  localparam int Q_BT1      = 23167;    // 0.3535
  localparam int Q_BT2      = 48549;    // 0.7408
  localparam int Q_BT3      = 63203;    // 0.9644
  localparam int Q_BOFF1    = 35861;    // 0.54719
  localparam int Q_BOFF2    = 55876;    // 0.8526
  localparam int Q_BOFF3    = 68387;    // 1.0435
  localparam int Q_BBASE1   = 45875;    // 0.7
  localparam int Q_BBASE2   = 58982;    // 0.9
  localparam int Q_BBASE3   = 62259;    // 0.95
  localparam int Q_EIGHT    = 524288;   // 8.0

  // Taylor step divisors with reciprocal multipliers floor(2^s/k)
  localparam int NSTEP = 5;
  localparam int unsigned DIV_K [NSTEP] = '{110, 72, 42, 20, 6};
  localparam int unsigned DIV_S [NSTEP] = '{37, 37, 36, 35, 33};
  localparam logic [30:0] DIV_M [NSTEP] = '{31'd1249445031, 31'd1908874353,
                                           31'd1636178017, 31'd1717986918,
                                           31'd1431655765};

  // fields that ride along the pipeline
  typedef struct packed {
    logic [SEL_W-1:0]        sel;
    logic [IN_W-1:0]         t;
    logic [1:0]              quad;
    logic [28:0]             x;
    logic [29:0]             x2;
    logic signed [OUT_W-1:0] res;
  } side_t;

  // reciprocal quotient fix-up, then one minus quotient (Q.28)
  function automatic logic [28:0] horner_fix(input logic [61:0] qp,
                                             input logic [30:0] v,
                                             input int unsigned k,
                                             input int unsigned s);
    logic [31:0] q0;
    logic [31:0] rem;
    logic [31:0] q;
    q0  = 32'(qp >> s);
    rem = 32'(v) - q0 * 32'(k);
    q   = (rem >= 32'(k)) ? q0 + 32'd1 : q0;
    return 29'((33'd1 << SIN_G) - 33'(q));
  endfunction

endpackage

[rtl/core/easing_curve_unit.sv]
// Easing curve unit: pipelined evaluator of nine animation easing curves.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+---------------------------
//  input   | in_valid, in_stall, func, progress | in_valid && !in_stall
//  output  | out_valid, out_stall, eased       | out_valid && !out_stall
//
// 22 register stages, one transfer per cycle while the output is not stalled.
// Depth is set by the sine path: phase multiply, square, five Taylor steps of
// three stages each (product, reciprocal multiply, quotient fix-up), final scale.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled result freezes the whole pipe; in_stall follows it in the same cycle.
module easing_curve_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ecu_pkg::SEL_W-1:0]         func,
  input  logic [ecu_pkg::IN_W-1:0]          progress,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ecu_pkg::OUT_W-1:0]  eased
);
  import ecu_pkg::*;

  localparam int NST = 22;

  logic [NST:1] vld;
  logic         adv;
  side_t        side [1:NST];

  // pipe moves unless the output holds a result that is not taken
  assign adv       = !(vld[NST] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-1:1], in_valid};
    end
  end

  // ---------------- stage 2 combinational: phase fold, poly operands ------
  logic [PH_W-1:0]          ph2c;
  logic [15:0]              r2c;
  logic [16:0]              rr2c;
  logic [33:0]              bxp2c;
  logic signed [17:0]       u2c;
  logic signed [37:0]       kup2c;

  always_comb begin
    // phase in turns: t/2 + 0.25 turn for the cosine curve, 2t for the cycle curve
    if (side[1].sel == FN_ACCDEC) begin
      ph2c = {side[1].t, 1'b0} + PH_W'(Q_ONE);
    end else begin
      ph2c = {side[1].t[14:0], 3'b000};
    end
    r2c  = ph2c[15:0];
    rr2c = ph2c[16] ? 17'd65536 - {1'b0, r2c} : {1'b0, r2c};
    bxp2c = 34'(side[1].t) * 34'(Q_BX_SCALE) + 34'd32768;
    case (side[1].sel)
      FN_ANTICOVER: begin
        if (side[1].t < 17'd32768) begin
          u2c = $signed({side[1].t, 1'b0});
        end else begin
          u2c = $signed({side[1].t, 1'b0}) - 18'sd131072;
        end
      end
      FN_OVERSHOOT: u2c = $signed({1'b0, side[1].t}) - 18'sd65536;
      default:      u2c = '0;
    endcase
    kup2c = 38'(u2c) * 38'sd163840 + 38'sd32768;
  end

  logic [16:0]        rr2;
  logic [16:0]        bx2;
  logic signed [17:0] u2;
  logic signed [19:0] ku2;
  logic               lo2;

  // ---------------- stage 3 combinational: square operand and factor -------
  logic signed [17:0] a3c;
  logic signed [20:0] c3c;
  logic signed [18:0] addc3c;
  logic               neg3c, halve3c, csq3c;

  always_comb begin
    a3c     = '0;
    c3c     = '0;
    addc3c  = '0;
    neg3c   = 1'b0;
    halve3c = 1'b0;
    csq3c   = 1'b0;
    case (side[2].sel)
      FN_ACCEL: begin
        a3c = $signed({1'b0, side[2].t});
        c3c = 21'sd65536;
      end
      FN_ANTIC: begin
        a3c = $signed({1'b0, side[2].t});
        c3c = 21'($signed({1'b0, side[2].t, 1'b0})) - 21'sd65536;
      end
      FN_ANTICOVER: begin
        a3c     = u2;
        c3c     = lo2 ? 21'(ku2) - 21'(Q_K32) : 21'(ku2) + 21'(Q_K32);
        addc3c  = lo2 ? 19'sd0 : 19'sd131072;
        halve3c = 1'b1;
      end
      FN_OVERSHOOT: begin
        a3c    = u2;
        c3c    = 21'(ku2) + 21'(Q_K32);
        addc3c = 19'sd65536;
      end
      FN_BOUNCE: begin
        c3c = 21'(Q_EIGHT);
        if (bx2 < 17'(Q_BT1)) begin
          a3c = $signed({1'b0, bx2});
        end else if (bx2 < 17'(Q_BT2)) begin
          a3c    = $signed({1'b0, bx2}) - 18'(Q_BOFF1);
          addc3c = 19'(Q_BBASE1);
        end else if (bx2 < 17'(Q_BT3)) begin
          a3c    = $signed({1'b0, bx2}) - 18'(Q_BOFF2);
          addc3c = 19'(Q_BBASE2);
        end else begin
          a3c    = $signed({1'b0, bx2}) - 18'(Q_BOFF3);
          addc3c = 19'(Q_BBASE3);
        end
      end
      FN_DECEL: begin
        // 1 - ((1-t)^2)^2
        a3c    = 18'sd65536 - $signed({1'b0, side[2].t});
        csq3c  = 1'b1;
        neg3c  = 1'b1;
        addc3c = 19'sd65536;
      end
      default: ;
    endcase
  end

  logic signed [17:0] a3;
  logic signed [20:0] c3, c4;
  logic signed [18:0] addc3, addc4, addc5;
  logic               neg3, neg4, neg5;
  logic               halve3, halve4, halve5, halve6;
  logic               csq3, csq4;
  logic signed [17:0] sq4;
  logic signed [35:0] sqp4c;
  logic signed [38:0] p5;
  logic signed [20:0] opnd5c;
  logic signed [23:0] m6c;
  logic signed [23:0] y6;
  logic signed [23:0] yh7c;
  logic signed [OUT_W-1:0] res7c;
  logic [47:0]        xp3;

  assign sqp4c  = 36'(a3) * 36'(a3) + 36'sd32768;
  assign opnd5c = csq4 ? 21'(sq4) : c4;
  assign m6c    = 24'((p5 + 39'sd32768) >>> 16);

  always_comb begin
    yh7c = halve6 ? (y6 + 24'sd1) >>> 1 : y6;
    case (side[6].sel)
      FN_ACCEL, FN_ANTIC, FN_ANTICOVER, FN_BOUNCE, FN_DECEL, FN_OVERSHOOT: begin
        if (yh7c > 24'sd131071) begin
          res7c = 18'sd131071;
        end else if (yh7c < -24'sd131072) begin
          res7c = -18'sd131072;
        end else begin
          res7c = 18'(yh7c);
        end
      end
      default: res7c = $signed({1'b0, side[6].t});
    endcase
  end

  // ---------------- Taylor steps ------------------------------------------
  logic [30:0] vreg  [NSTEP];
  logic [30:0] vq    [NSTEP];
  logic [61:0] qpr   [NSTEP];
  logic [28:0] hstep [NSTEP+1];

  genvar j;
  for (j = 0; j < NSTEP; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (j == 0) begin
          vreg[j] <= 31'(side[5].x2);
        end else begin
          vreg[j] <= 31'((59'(side[5+3*j].x2) * 59'(hstep[j])) >> SIN_G);
        end
        qpr[j]     <= 62'(vreg[j]) * 62'(DIV_M[j]);
        vq[j]      <= vreg[j];
        hstep[j+1] <= horner_fix(qpr[j], vq[j], DIV_K[j], DIV_S[j]);
      end
    end
  end
  assign hstep[0] = '0;

  // ---------------- final sine scale and output select --------------------
  logic [28:0]          hf21;
  logic signed [29:0]   s22c;
  logic signed [30:0]   o22c;

  always_comb begin
    s22c = side[21].quad[1] ? -$signed({1'b0, hf21}) : $signed({1'b0, hf21});
    case (side[21].sel)
      FN_ACCDEC: o22c = (31'sd268435456 - 31'(s22c) + 31'sd4096) >>> 13;
      FN_CYCLE:  o22c = (31'(s22c) + 31'sd2048) >>> 12;
      default:   o22c = 31'(side[21].res);
    endcase
  end

  // ---------------- side words that pick up a new field ------------------
  side_t s1c, s2c, s4c, s5c, s7c;

  always_comb begin
    s1c     = '0;
    s1c.sel = func;
    s1c.t   = (progress > IN_W'(Q_ONE)) ? IN_W'(Q_ONE) : progress;
    s2c      = side[1];
    s2c.quad = ph2c[17:16];
    s4c   = side[3];
    s4c.x = 29'((xp3 + 48'd131072) >> PH_W);
    s5c    = side[4];
    s5c.x2 = 30'((58'(side[4].x) * 58'(side[4].x)) >> SIN_G);
    s7c     = side[6];
    s7c.res = res7c;
  end

  // ---------------- datapath registers -------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= s1c;
      side[2] <= s2c;
      side[4] <= s4c;
      side[5] <= s5c;
      side[7] <= s7c;
      for (int i = 3; i <= NST; i++) begin
        if (i != 4 && i != 5 && i != 7) begin
          side[i] <= side[i-1];
        end
      end
      // stage 2
      rr2 <= rr2c;
      bx2 <= 17'(bxp2c >> 16);
      u2  <= u2c;
      ku2 <= 20'(kup2c >>> 16);
      lo2 <= side[1].t < 17'd32768;
      // stage 3
      xp3    <= 48'(rr2) * 48'(TWO_PI_G);
      a3     <= a3c;
      c3     <= c3c;
      addc3  <= addc3c;
      neg3   <= neg3c;
      halve3 <= halve3c;
      csq3   <= csq3c;
      // stage 4
      sq4    <= 18'(sqp4c >>> 16);
      c4     <= c3;
      addc4  <= addc3;
      neg4   <= neg3;
      halve4 <= halve3;
      csq4   <= csq3;
      // stage 5
      p5     <= 39'(sq4) * 39'(opnd5c);
      addc5  <= addc4;
      neg5   <= neg4;
      halve5 <= halve4;
      // stage 6
      y6     <= neg5 ? 24'(addc5) - m6c : m6c + 24'(addc5);
      halve6 <= halve5;
      // stage 21
      hf21 <= 29'((58'(side[20].x) * 58'(hstep[NSTEP])) >> SIN_G);
      // stage 22
      eased <= OUT_W'(o22c);
    end
  end

endmodule
